// File: hdl/sae_pkg.sv
// Package for the simplex affine map engine.
// Operand widths, unsigned Q1.30 geometry constants, command and register codes, helpers.
// No dependencies.
package sae_pkg;

   localparam int SAE_FRAC_BITS = 16;
   localparam int SPACE_DIM     = 3;
   localparam int NUM_VERTS     = 4;

   // shared multiplier operand and result widths
   localparam int OPA_W  = 36;
   localparam int OPB_W  = 33;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int TERM_W = PROD_W + 1;
   localparam int ACC_W  = TERM_W + 2;

   // unsigned Q1.30 constants: 1/sqrt(3), 1/sqrt(6), and 1.0
   localparam logic [30:0] CONST_A  = 31'd619925131;
   localparam logic [30:0] CONST_B  = 31'd438353264;
   localparam logic [30:0] ONE_Q30  = 31'd1073741824;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_MAP_FWD  = 2'd1;
   localparam logic [1:0] CMD_MAP_BACK = 2'd2;

   localparam logic [1:0] CSR_GEOM_DIM  = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;

   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [OPA_W-1:0] a;
      logic signed [OPB_W-1:0] b;
      logic                    q30;   // round at 30 fraction bits instead of FRAC_BITS
      logic                    neg;   // subtract the rounded product
   } mul_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) begin
         return v[31:0];
      end
      return v[ACC_W-1] ? Q_MIN : Q_MAX;
   endfunction

   function automatic logic [1:0] nxt3(input logic [1:0] i);
      return (i == 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

   function automatic logic [1:0] prv3(input logic [1:0] i);
      return (i == 2'd0) ? 2'd2 : i - 2'd1;
   endfunction

endpackage

// File: hdl/sae_mul.sv
// Shared multiply and round unit of the simplex affine map engine.
// Depends on sae_pkg (mul_req_type, widths).
module sae_mul import sae_pkg::*; #(
   parameter int FRAC_BITS = SAE_FRAC_BITS
) (
   input  logic                     clock,
   input  mul_req_type              req,
   output logic signed [TERM_W-1:0] term
);

   localparam logic signed [TERM_W-1:0] RND_Q30  = TERM_W'(1) <<< 29;
   localparam logic signed [TERM_W-1:0] RND_FRAC = TERM_W'(1) <<< (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod;
   logic signed [TERM_W-1:0] rnd;
   logic signed [TERM_W-1:0] shifted;
   logic signed [TERM_W-1:0] term_ff;

   always_comb begin
      prod    = req.a * req.b;
      rnd     = $signed({prod[PROD_W-1], prod}) + (req.q30 ? RND_Q30 : RND_FRAC);
      shifted = req.q30 ? (rnd >>> 30) : (rnd >>> FRAC_BITS);
   end

   // round half up, then negate when the term is subtracted
   always_ff @(posedge clock) begin
      term_ff <= req.neg ? -shifted : shifted;
   end

   assign term = term_ff;

endmodule

// File: hdl/sae_div.sv
// Bit-serial restoring divider for the inverse entries: (num << FRAC_BITS) / den,
// rounded half away from zero and saturated to 32 bits. Depends on sae_pkg.
module sae_div import sae_pkg::*; #(
   parameter int FRAC_BITS = SAE_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [OPB_W-1:0] num,
   input  logic signed [31:0]      den,
   output logic                    done,
   output logic signed [31:0]      quo
);

   localparam int NW = 33 + FRAC_BITS;

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type         st_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        rem_ff;
   logic [30:0]        low_ff;
   logic [30:0]        q_ff;
   logic               neg_ff;
   logic               done_ff;
   logic signed [31:0] quo_ff;

   logic [32:0]   num_mag;
   logic [31:0]   nm;
   logic [31:0]   dm;
   logic [NW-1:0] nfull;
   logic          ovf;
   logic [32:0]   rem2;
   logic [32:0]   rem_sub;
   logic          ge;
   logic [30:0]   q_next;
   logic [31:0]   q_ext;

   always_comb begin
      num_mag = num[OPB_W-1] ? 33'(-num) : 33'(num);
      nm      = num_mag[31:0];
      dm      = den[31] ? 32'(-den) : 32'(den);
      nfull   = NW'({nm, {FRAC_BITS{1'b0}}}) + NW'(dm >> 1);
      ovf     = 64'(nfull) >= {1'b0, dm, 31'd0};
      rem2    = {rem_ff, low_ff[30]};
      ge      = rem2 >= {1'b0, dm};
      rem_sub = rem2 - {1'b0, dm};
      q_next  = {q_ff[29:0], ge};
      q_ext   = {1'b0, q_next};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= D_IDLE;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         low_ff  <= '0;
         q_ff    <= '0;
         neg_ff  <= 1'b0;
         done_ff <= 1'b0;
         quo_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff <= num[OPB_W-1] ^ den[31];
                  if (ovf) begin
                     quo_ff  <= (num[OPB_W-1] ^ den[31]) ? Q_MIN : Q_MAX;
                     done_ff <= 1'b1;
                  end else begin
                     rem_ff <= 32'(nfull >> 31);
                     low_ff <= nfull[30:0];
                     q_ff   <= '0;
                     cnt_ff <= 5'd30;
                     st_ff  <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff <= ge ? rem_sub[31:0] : rem2[31:0];
               low_ff <= {low_ff[29:0], 1'b0};
               q_ff   <= q_next;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  quo_ff  <= neg_ff ? -q_ext : q_ext;
                  done_ff <= 1'b1;
                  st_ff   <= D_IDLE;
               end
            end
            default: st_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: hdl/simplex_affine_map_engine.sv
// Top level of the simplex affine map engine: sequencer, matrix registers, ports.
// Depends on sae_pkg, sae_mul and sae_div.
//
// Loads triangle or tetrahedron vertices one transfer at a time; the last vertex
// (slot 2 for a triangle, 3 for a tetrahedron) builds the Jacobian of the map from
// the equilateral reference simplex, its cofactor inverse and |det|, then returns
// one result per matrix row (two or three transfers, last row flagged). Commands
// 1 and 2 map one point forward or back and return one result. All values are
// signed fixed point with FRAC_BITS fraction bits, saturated to 32 bits; a
// determinant below singular_threshold (or zero) sets singular and zeroes the
// inverse. The block handles one item at a time and holds req_ready low until the
// last result has been taken. A map runs nine products through the one shared
// multiplier. A final vertex runs the Jacobian (nine products), the cofactors
// (eighteen products for a tetrahedron, one direct step for a triangle), the
// determinant (three or two products), the singular check, then nine divisions
// on the bit-serial divider; a singular cell skips the divisions. Configuration
// writes land on csr_we with no handshake and should only come while the block
// is idle.
module simplex_affine_map_engine import sae_pkg::*; #(
   parameter int FRAC_BITS = SAE_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic               req_is_tetra,
   input  logic [1:0]         req_vertex_slot,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [1:0]         rsp_row,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_inv0,
   output logic signed [31:0] rsp_inv1,
   output logic signed [31:0] rsp_inv2,
   output logic [30:0]        rsp_det_abs,
   output logic               rsp_singular,
   output logic               rsp_last,
   // configuration
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_JAC, S_TCOF, S_COF, S_DET, S_SING, S_DIV, S_MAP, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] ri_ff, cj_ff, tk_ff;
   logic       ph_ff;          // 0: issue product, 1: accumulate it
   logic       div_wait_ff;
   logic       tetra_ff;
   logic       fwd_ff;
   logic       kind_ff;
   logic [1:0] out_row_ff;
   logic [1:0] last_row_ff;
   logic [1:0] geom_ff;
   logic [15:0] thresh_ff;

   logic signed [31:0]      vs_ff  [NUM_VERTS][SPACE_DIM];
   logic signed [31:0]      jac_ff [SPACE_DIM][SPACE_DIM];
   logic signed [31:0]      inv_ff [SPACE_DIM][SPACE_DIM];
   logic signed [OPB_W-1:0] cof_ff [SPACE_DIM][SPACE_DIM];
   logic signed [31:0]      det_ff;
   logic [30:0]             det_abs_ff;
   logic                    sing_ff;
   logic signed [31:0]      pt_ff  [SPACE_DIM];
   logic signed [31:0]      res_ff [SPACE_DIM];
   logic signed [ACC_W-1:0] acc_ff;

   mul_req_type             mul_req;
   logic signed [TERM_W-1:0] mul_term;
   logic                    div_start;
   logic                    div_done;
   logic signed [31:0]      div_quo;

   logic                    dim3, row_on, col_on;
   logic [1:0]              i1, i2, j1, j2;
   logic signed [OPA_W-1:0] e0, e1, e2, e3, jsum;
   logic [30:0]             jconst;
   logic                    first_term;
   logic signed [ACC_W-1:0] init_val, sum;
   logic signed [31:0]      sum_sat;
   logic [31:0]             det_mag;
   logic [30:0]             det_abs_c;
   logic                    sing_c;
   logic                    det_last;
   logic                    accept;
   logic signed [31:0]      req_coord [SPACE_DIM];

   assign accept       = req_valid && req_ready;
   assign req_coord[0] = req_coord_x;
   assign req_coord[1] = req_coord_y;
   assign req_coord[2] = req_coord_z;

   // ---- operand selection for the shared multiplier ----
   always_comb begin
      dim3   = (geom_ff == 2'd3);
      row_on = (ri_ff != 2'd2) || dim3;
      col_on = (cj_ff != 2'd2) || dim3;
      i1 = nxt3(ri_ff);
      i2 = prv3(ri_ff);
      j1 = nxt3(cj_ff);
      j2 = prv3(cj_ff);

      // vertex coordinates outside the active dimension count as zero
      e0 = row_on ? OPA_W'(vs_ff[0][ri_ff]) : '0;
      e1 = row_on ? OPA_W'(vs_ff[1][ri_ff]) : '0;
      e2 = row_on ? OPA_W'(vs_ff[2][ri_ff]) : '0;
      e3 = row_on ? OPA_W'(vs_ff[3][ri_ff]) : '0;

      case (cj_ff)
         2'd0: begin
            jsum   = (e1 <<< 1) - e0 - e2;
            jconst = CONST_A;
         end
         2'd1: begin
            jsum   = e2 - e0;
            jconst = ONE_Q30;
         end
         default: begin
            jsum   = tetra_ff ? ((e3 <<< 1) + e3 - e0 - e1 - e2) : '0;
            jconst = CONST_B;
         end
      endcase
      if (ri_ff == 2'd2 && !tetra_ff) begin
         jsum = '0;
      end

      mul_req = '0;
      case (state_ff)
         S_JAC: begin
            mul_req.a   = jsum;
            mul_req.b   = $signed({2'b00, jconst});
            mul_req.q30 = 1'b1;
         end
         S_COF: begin
            if (tk_ff == 2'd0) begin
               mul_req.a = OPA_W'(jac_ff[i1][j1]);
               mul_req.b = OPB_W'(jac_ff[i2][j2]);
            end else begin
               mul_req.a   = OPA_W'(jac_ff[i1][j2]);
               mul_req.b   = OPB_W'(jac_ff[i2][j1]);
               mul_req.neg = 1'b1;
            end
         end
         S_DET: begin
            if (tetra_ff) begin
               mul_req.a = OPA_W'(jac_ff[tk_ff][0]);
               mul_req.b = cof_ff[tk_ff][0];
            end else if (tk_ff == 2'd0) begin
               mul_req.a = OPA_W'(jac_ff[0][0]);
               mul_req.b = OPB_W'(jac_ff[1][1]);
            end else begin
               mul_req.a   = OPA_W'(jac_ff[0][1]);
               mul_req.b   = OPB_W'(jac_ff[1][0]);
               mul_req.neg = 1'b1;
            end
         end
         S_MAP: begin
            if (row_on) begin
               mul_req.a = fwd_ff ? OPA_W'(jac_ff[ri_ff][cj_ff]) : OPA_W'(inv_ff[ri_ff][cj_ff]);
            end
            if (col_on) begin
               mul_req.b = fwd_ff ? OPB_W'(pt_ff[cj_ff])
                                  : OPB_W'(pt_ff[cj_ff]) - OPB_W'(vs_ff[0][cj_ff]);
            end
         end
         default: mul_req = '0;
      endcase
   end

   // ---- accumulate ----
   always_comb begin
      case (state_ff)
         S_MAP:   first_term = (cj_ff == 2'd0);
         S_JAC:   first_term = 1'b1;
         default: first_term = (tk_ff == 2'd0);
      endcase
      init_val = (state_ff == S_MAP && fwd_ff && row_on) ? ACC_W'(vs_ff[0][ri_ff]) : '0;
      sum      = (first_term ? init_val : acc_ff) + ACC_W'(mul_term);
      sum_sat  = sat32(sum);
      det_last = tetra_ff ? (tk_ff == 2'd2) : (tk_ff == 2'd1);

      det_mag   = det_ff[31] ? 32'(-det_ff) : 32'(det_ff);
      det_abs_c = det_mag[31] ? 31'h7fffffff : det_mag[30:0];
      sing_c    = (det_ff == '0) || (det_abs_c < {15'd0, thresh_ff});
   end

   assign div_start = (state_ff == S_DIV) && !div_wait_ff;

   sae_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .req   (mul_req),
      .term  (mul_term)
   );

   sae_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (cof_ff[cj_ff][ri_ff]),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ri_ff       <= '0;
         cj_ff       <= '0;
         tk_ff       <= '0;
         ph_ff       <= 1'b0;
         div_wait_ff <= 1'b0;
         tetra_ff    <= 1'b0;
         fwd_ff      <= 1'b0;
         kind_ff     <= 1'b0;
         out_row_ff  <= '0;
         last_row_ff <= '0;
         geom_ff     <= 2'd3;
         thresh_ff   <= 16'd1;
         det_ff      <= '0;
         det_abs_ff  <= '0;
         sing_ff     <= 1'b0;
         acc_ff      <= '0;
         for (int v = 0; v < NUM_VERTS; v++) begin
            for (int c = 0; c < SPACE_DIM; c++) begin
               vs_ff[v][c] <= '0;
            end
         end
         for (int r = 0; r < SPACE_DIM; r++) begin
            pt_ff[r]  <= '0;
            res_ff[r] <= '0;
            for (int c = 0; c < SPACE_DIM; c++) begin
               jac_ff[r][c] <= '0;
               inv_ff[r][c] <= '0;
               cof_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_GEOM_DIM:  geom_ff   <= csr_wdata[1:0];
               CSR_THRESHOLD: thresh_ff <= csr_wdata;
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ri_ff <= '0;
                  cj_ff <= '0;
                  tk_ff <= '0;
                  ph_ff <= 1'b0;
                  case (req_cmd) inside
                     CMD_LOAD: begin
                        for (int c = 0; c < SPACE_DIM; c++) begin
                           vs_ff[req_vertex_slot][c] <= req_coord[c];
                        end
                        if (req_vertex_slot == (req_is_tetra ? 2'd3 : 2'd2)) begin
                           tetra_ff <= req_is_tetra;
                           state_ff <= S_JAC;
                        end
                     end
                     CMD_MAP_FWD, CMD_MAP_BACK: begin
                        fwd_ff <= (req_cmd == CMD_MAP_FWD);
                        for (int c = 0; c < SPACE_DIM; c++) begin
                           pt_ff[c] <= req_coord[c];
                        end
                        state_ff <= S_MAP;
                     end
                     default: ;   // drop the unused command
                  endcase
               end
            end

            S_JAC: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) begin
                  jac_ff[ri_ff][cj_ff] <= sum_sat;
                  cj_ff <= nxt3(cj_ff);
                  if (cj_ff == 2'd2) begin
                     ri_ff <= nxt3(ri_ff);
                     if (ri_ff == 2'd2) begin
                        state_ff <= tetra_ff ? S_COF : S_TCOF;
                     end
                  end
               end
            end

            S_TCOF: begin
               // planar cell: cofactors of the upper 2x2 block, the rest zero
               cof_ff[0][0] <= OPB_W'(jac_ff[1][1]);
               cof_ff[0][1] <= -OPB_W'(jac_ff[1][0]);
               cof_ff[0][2] <= '0;
               cof_ff[1][0] <= -OPB_W'(jac_ff[0][1]);
               cof_ff[1][1] <= OPB_W'(jac_ff[0][0]);
               cof_ff[1][2] <= '0;
               for (int c = 0; c < SPACE_DIM; c++) begin
                  cof_ff[2][c] <= '0;
               end
               state_ff <= S_DET;
            end

            S_COF: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) begin
                  if (tk_ff == 2'd0) begin
                     acc_ff <= sum;
                     tk_ff  <= 2'd1;
                  end else begin
                     cof_ff[ri_ff][cj_ff] <= OPB_W'(sum_sat);
                     tk_ff <= 2'd0;
                     cj_ff <= nxt3(cj_ff);
                     if (cj_ff == 2'd2) begin
                        ri_ff <= nxt3(ri_ff);
                        if (ri_ff == 2'd2) begin
                           state_ff <= S_DET;
                        end
                     end
                  end
               end
            end

            S_DET: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) begin
                  if (det_last) begin
                     det_ff   <= sum_sat;
                     tk_ff    <= '0;
                     state_ff <= S_SING;
                  end else begin
                     acc_ff <= sum;
                     tk_ff  <= tk_ff + 2'd1;
                  end
               end
            end

            S_SING: begin
               det_abs_ff <= det_abs_c;
               sing_ff    <= sing_c;
               ri_ff      <= '0;
               cj_ff      <= '0;
               div_wait_ff <= 1'b0;
               if (sing_c) begin
                  for (int r = 0; r < SPACE_DIM; r++) begin
                     for (int c = 0; c < SPACE_DIM; c++) begin
                        inv_ff[r][c] <= '0;
                     end
                  end
                  kind_ff     <= 1'b0;
                  out_row_ff  <= '0;
                  last_row_ff <= tetra_ff ? 2'd2 : 2'd1;
                  state_ff    <= S_OUT;
               end else begin
                  state_ff <= S_DIV;
               end
            end

            S_DIV: begin
               if (!div_wait_ff) begin
                  div_wait_ff <= 1'b1;
               end else if (div_done) begin
                  inv_ff[ri_ff][cj_ff] <= div_quo;
                  div_wait_ff <= 1'b0;
                  cj_ff <= nxt3(cj_ff);
                  if (cj_ff == 2'd2) begin
                     ri_ff <= nxt3(ri_ff);
                     if (ri_ff == 2'd2) begin
                        kind_ff     <= 1'b0;
                        out_row_ff  <= '0;
                        last_row_ff <= tetra_ff ? 2'd2 : 2'd1;
                        state_ff    <= S_OUT;
                     end
                  end
               end
            end

            S_MAP: begin
               ph_ff <= ~ph_ff;
               if (ph_ff) begin
                  cj_ff <= nxt3(cj_ff);
                  if (cj_ff == 2'd2) begin
                     res_ff[ri_ff] <= sum_sat;
                     ri_ff <= nxt3(ri_ff);
                     if (ri_ff == 2'd2) begin
                        kind_ff     <= 1'b1;
                        out_row_ff  <= '0;
                        last_row_ff <= '0;
                        state_ff    <= S_OUT;
                     end
                  end else begin
                     acc_ff <= sum;
                  end
               end
            end

            S_OUT: begin
               // hold each row until its transfer, then advance
               if (rsp_ready) begin
                  if (out_row_ff == last_row_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     out_row_ff <= out_row_ff + 2'd1;
                  end
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---- ports ----
   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = (state_ff == S_OUT);
   assign rsp_kind     = kind_ff;
   assign rsp_row      = out_row_ff;
   assign rsp_col0     = kind_ff ? res_ff[0] : jac_ff[out_row_ff][0];
   assign rsp_col1     = kind_ff ? res_ff[1] : jac_ff[out_row_ff][1];
   assign rsp_col2     = kind_ff ? res_ff[2] : jac_ff[out_row_ff][2];
   assign rsp_inv0     = kind_ff ? '0 : inv_ff[out_row_ff][0];
   assign rsp_inv1     = kind_ff ? '0 : inv_ff[out_row_ff][1];
   assign rsp_inv2     = kind_ff ? '0 : inv_ff[out_row_ff][2];
   assign rsp_det_abs  = det_abs_ff;
   assign rsp_singular = sing_ff;
   assign rsp_last     = (out_row_ff == last_row_ff);

   // ---- assertions ----
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind && rsp_singular) |->
         (rsp_inv0 == '0 && rsp_inv1 == '0 && rsp_inv2 == '0))
      else $error("singular cell with nonzero inverse");

   a_map_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_last && rsp_row == 2'd0))
      else $error("mapped point not a single final result");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV && div_wait_ff))
      else $error("divider finished outside the division pass");

endmodule

// File: tb/sv/tb_simplex_affine_map_engine.sv
// Testbench for the simplex affine map engine: drives vertex loads, point maps and unused commands
// over the request channel, writes registers, predicts every result and checks it field by field.
// Depends on sae_pkg and the simplex_affine_map_engine RTL.
`timescale 1ns / 1ps

module tb_simplex_affine_map_engine import sae_pkg::*;;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic        kind;
      logic [1:0]  row;
      logic signed [31:0] col [3];
      logic signed [31:0] inv [3];
      logic [30:0] det_abs;
      logic        singular;
      logic        last;
   } map_result_type;

   int unsigned error_count = 0;

   task automatic report_mismatch(input string what);
      $display("tb: mismatch %s at %0t", what, $realtime);
      error_count++;
   endtask

   // Scoreboard: predictor state plus the queue of results still owed by the block.
   class map_scoreboard;
      logic signed [31:0] verts [4][3];
      logic signed [31:0] jac [3][3];
      logic signed [31:0] kinv [3][3];
      logic [31:0] det_mag;
      bit          sing;
      int unsigned dim_reg;
      int unsigned thresh_reg;
      map_result_type pending [$];

      function new();
         foreach (verts[v, i]) verts[v][i] = 0;
         foreach (jac[i, j]) begin
            jac[i][j] = 0;
            kinv[i][j] = 0;
         end
         det_mag = 0;
         sing = 0;
         dim_reg = 3;
         thresh_reg = 1;
      endfunction

      function void write_reg(input logic [1:0] idx, input logic [15:0] val);
         if (idx == CSR_GEOM_DIM) dim_reg = val & 3;
         else if (idx == CSR_THRESHOLD) thresh_reg = val;
      endfunction

      static function longint rshift_round(input longint v, input int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      static function logic signed [31:0] clip32(input longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      static function longint qmul(input longint x, input longint y);
         return rshift_round(x * y, SAE_FRAC_BITS);
      endfunction

      static function logic signed [31:0] qdivide(input longint num, input longint den);
         logic [63:0] nm, dm, q;
         bit neg;
         nm = num < 0 ? -num : num;
         dm = den < 0 ? -den : den;
         q = ((nm << SAE_FRAC_BITS) + dm / 2) / dm;
         neg = (num < 0) != (den < 0);
         if (q > 64'd2147483647) return neg ? 32'sh80000000 : 32'sh7fffffff;
         return neg ? 32'(-longint'(q)) : 32'(q);
      endfunction

      // Rebuild Jacobian, cofactor inverse and |det| from the stored vertices.
      function void rebuild(input bit tetra);
         longint p [4][3];
         longint cof [3][3];
         longint det, mag;
         int g;
         g = dim_reg < 2 ? 2 : dim_reg;
         foreach (p[v, i]) p[v][i] = (i < g) ? longint'(verts[v][i]) : 0;
         foreach (jac[i, j]) begin
            jac[i][j] = 0;
            cof[i][j] = 0;
         end
         for (int i = 0; i < (tetra ? 3 : 2); i++) begin
            jac[i][0] = clip32(rshift_round(longint'(CONST_A) *
                               (2 * p[1][i] - p[0][i] - p[2][i]), 30));
            jac[i][1] = clip32(p[2][i] - p[0][i]);
            if (tetra)
               jac[i][2] = clip32(rshift_round(longint'(CONST_B) *
                                  (3 * p[3][i] - p[0][i] - p[1][i] - p[2][i]), 30));
         end
         if (tetra) begin
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  cof[i][j] = clip32(qmul(jac[(i+1)%3][(j+1)%3], jac[(i+2)%3][(j+2)%3])
                                   - qmul(jac[(i+1)%3][(j+2)%3], jac[(i+2)%3][(j+1)%3]));
            det = clip32(qmul(jac[0][0], cof[0][0]) + qmul(jac[1][0], cof[1][0])
                       + qmul(jac[2][0], cof[2][0]));
         end else begin
            cof[0][0] = jac[1][1];
            cof[0][1] = -longint'(jac[1][0]);
            cof[1][0] = -longint'(jac[0][1]);
            cof[1][1] = jac[0][0];
            det = clip32(qmul(jac[0][0], jac[1][1]) - qmul(jac[0][1], jac[1][0]));
         end
         mag = det < 0 ? -det : det;
         det_mag = mag > 64'sd2147483647 ? 32'h7fffffff : mag[31:0];
         sing = (det == 0) || (det_mag < thresh_reg);
         foreach (kinv[i, j]) kinv[i][j] = sing ? 32'sd0 : qdivide(cof[j][i], det);
      endfunction

      // Note one accepted request and queue the results it causes.
      function void note_request(input logic [1:0] cmd, input bit tetra,
                                 input logic [1:0] slot, input logic signed [31:0] c [3]);
         map_result_type r;
         longint acc;
         int g, rows;
         g = dim_reg < 2 ? 2 : dim_reg;
         if (cmd == CMD_LOAD) begin
            for (int i = 0; i < 3; i++) verts[slot][i] = c[i];
            if (slot != (tetra ? 2'd3 : 2'd2)) return;
            rebuild(tetra);
            rows = tetra ? 3 : 2;
            for (int i = 0; i < rows; i++) begin
               r.kind = 0;
               r.row = 2'(i);
               for (int j = 0; j < 3; j++) begin
                  r.col[j] = jac[i][j];
                  r.inv[j] = kinv[i][j];
               end
               r.det_abs = det_mag[30:0];
               r.singular = sing;
               r.last = (i == rows - 1);
               pending.push_back(r);
            end
         end else if (cmd == CMD_MAP_FWD || cmd == CMD_MAP_BACK) begin
            r.kind = 1;
            r.row = 0;
            for (int j = 0; j < 3; j++) begin
               r.col[j] = 0;
               r.inv[j] = 0;
            end
            for (int i = 0; i < g; i++) begin
               acc = (cmd == CMD_MAP_FWD) ? longint'(verts[0][i]) : 0;
               for (int j = 0; j < g; j++)
                  if (cmd == CMD_MAP_FWD) acc += qmul(jac[i][j], c[j]);
                  else acc += qmul(kinv[i][j], longint'(c[j]) - longint'(verts[0][j]));
               r.col[i] = clip32(acc);
            end
            r.det_abs = det_mag[30:0];
            r.singular = sing;
            r.last = 1;
            pending.push_back(r);
         end
      endfunction

      // Compare one accepted result with the oldest expectation.
      task check_result(input map_result_type got);
         map_result_type exp_r;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result");
            return;
         end
         exp_r = pending.pop_front();
         if (got.kind !== exp_r.kind) report_mismatch("kind");
         if (got.row !== exp_r.row) report_mismatch("row");
         for (int j = 0; j < 3; j++) begin
            if (got.col[j] !== exp_r.col[j])
               report_mismatch($sformatf("col%0d got %h exp %h", j, got.col[j], exp_r.col[j]));
            if (got.inv[j] !== exp_r.inv[j])
               report_mismatch($sformatf("inv%0d got %h exp %h", j, got.inv[j], exp_r.inv[j]));
         end
         if (got.det_abs !== exp_r.det_abs)
            report_mismatch($sformatf("det_abs got %h exp %h", got.det_abs, exp_r.det_abs));
         if (got.singular !== exp_r.singular) report_mismatch("singular");
         if (got.last !== exp_r.last) report_mismatch("last");
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [1:0] req_cmd = 0;
   logic req_is_tetra = 0;
   logic [1:0] req_vertex_slot = 0;
   logic signed [31:0] req_coord_x = 0, req_coord_y = 0, req_coord_z = 0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_kind, rsp_singular, rsp_last;
   logic [1:0] rsp_row;
   logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_inv0, rsp_inv1, rsp_inv2;
   logic [30:0] rsp_det_abs;
   logic csr_we = 0;
   logic [1:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;

   // idle percentages for the current phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   map_scoreboard sb = new();

   simplex_affine_map_engine dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run with a failure if it has not finished by this bound.
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // Receiver: randomly stall ready, check each transfer at the rising edge.
   initial begin
      map_result_type got;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.kind = rsp_kind;
            got.row = rsp_row;
            got.col[0] = rsp_col0;
            got.col[1] = rsp_col1;
            got.col[2] = rsp_col2;
            got.inv[0] = rsp_inv0;
            got.inv[1] = rsp_inv1;
            got.inv[2] = rsp_inv2;
            got.det_abs = rsp_det_abs;
            got.singular = rsp_singular;
            got.last = rsp_last;
            sb.check_result(got);
         end
      end
   end

   // Send one request; hold valid and payload until the transfer happens.
   // Valid drops only in idle cycles or when the caller stops sending.
   task automatic send_request(input logic [1:0] cmd, input bit tetra, input logic [1:0] slot,
                               input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z);
      logic signed [31:0] c [3];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_is_tetra <= tetra;
      req_vertex_slot <= slot;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, tetra, slot, c);
      @(negedge clock);
   endtask

   // Write a register once the block is idle: drain results, then allow latency.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(20 << 16)) - (10 << 16);
      endcase
   endfunction

   // Load a whole cell with random vertices, in slot order.
   task automatic load_cell(input bit tetra);
      for (int v = 0; v <= (tetra ? 3 : 2); v++)
         send_request(CMD_LOAD, tetra, 2'(v), rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic random_items(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         if (k < 3) load_cell(1'($urandom_range(1)));
         else if (k < 8)
            send_request($urandom_range(1) ? CMD_MAP_FWD : CMD_MAP_BACK,
                         1'($urandom_range(1)), 2'($urandom_range(3)),
                         rand_coord(), rand_coord(), rand_coord());
         else
            send_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                         2'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: unit triangle, unit tetrahedron, maps, singular and extreme cells.
      send_request(CMD_LOAD, 0, 0, 0, 0, 0);
      send_request(CMD_LOAD, 0, 1, 1 << 16, 0, 0);
      send_request(CMD_LOAD, 0, 2, 0, 1 << 16, 0);
      send_request(CMD_MAP_FWD, 0, 0, 1 << 15, 1 << 15, 1 << 15);
      send_request(CMD_MAP_BACK, 0, 0, 1 << 15, -(1 << 15), 7);
      send_request(CMD_LOAD, 1, 1, 1 << 16, 0, 0);
      send_request(CMD_LOAD, 1, 2, 0, 1 << 16, 0);
      send_request(CMD_LOAD, 1, 3, 0, 0, 1 << 16);
      send_request(CMD_MAP_BACK, 1, 0, 1 << 16, 1 << 16, 1 << 16);
      send_request(CMD_MAP_FWD, 1, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      // collinear (det zero) cell
      send_request(CMD_LOAD, 0, 1, 1 << 16, 1 << 16, 0);
      send_request(CMD_LOAD, 0, 2, 2 << 16, 2 << 16, 0);
      send_request(CMD_MAP_BACK, 0, 0, 5, 5, 5);
      // extreme coordinates saturate J and det
      send_request(CMD_LOAD, 1, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_request(CMD_LOAD, 1, 1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      send_request(CMD_LOAD, 1, 2, 32'sh80000000, 32'sh7fffffff, 32'shffffffff);
      send_request(CMD_LOAD, 1, 3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_request(CMD_UNUSED, 1, 3, 32'shffffffff, 32'shffffffff, 32'shffffffff);
      send_request(CMD_MAP_FWD, 1, 0, 32'shffffffff, 1, 32'sh80000000);

      // Register settings: 2D with largest threshold, dim 0 treated as 2, back to 3.
      write_reg(CSR_GEOM_DIM, 2);
      write_reg(CSR_THRESHOLD, 16'hffff);
      load_cell(0);
      send_request(CMD_MAP_BACK, 0, 0, 1 << 16, 1 << 16, 1 << 16);
      write_reg(CSR_THRESHOLD, 0);
      load_cell(1);
      write_reg(CSR_GEOM_DIM, 0);
      load_cell(0);
      write_reg(CSR_GEOM_DIM, 3);
      write_reg(CSR_THRESHOLD, 1);

      // Random phases: no idling, sender idle, receiver stall, both, then 2D with a random threshold.
      random_items(10);
      send_idle_pct = 60;
      random_items(10);
      send_idle_pct = 0;
      recv_stall_pct = 60;
      random_items(10);
      send_idle_pct = 10;
      recv_stall_pct = 10;
      random_items(10);
      write_reg(CSR_THRESHOLD, 16'($urandom_range(65535)));
      write_reg(CSR_GEOM_DIM, 2);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_items(6);

      // Drain, then allow a final vertex's worth of latency.
      req_valid <= 0;
      wait_cycles = 0;
      while (sb.pending.size() != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (400) @(negedge clock);
      if (sb.pending.size() != 0) report_mismatch("results left over");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/sae_pkg.sv
hdl/sae_mul.sv
hdl/sae_div.sv
hdl/simplex_affine_map_engine.sv
tb/sv/tb_simplex_affine_map_engine.sv
